@@ design/upac_pkg.sv @@
`default_nettype none

package upac_pkg;

  typedef logic [7:0]  char_t;
  typedef logic [31:0] count_t;

  // Default sizing
  localparam int SegmentBytesDef = 32;
  localparam int TableRowsDef    = 4;
  localparam int RowColumnsDef   = 4;

  // Fixed allowlist shape
  localparam int FixedRows  = 4;
  localparam int FixedCols  = 4;
  localparam int EntryChars = 16;

  localparam char_t  SLASH_CHAR = 8'h2F;
  localparam char_t  END_CHAR   = 8'h00;
  localparam count_t COUNT_MAX  = 32'hFFFF_FFFF;

  // Allowlist text, right-justified; column 0 is the first segment of a row.
  // Some entries are written as hex bytes.
  localparam logic [8*EntryChars-1:0] ENTRY_TEXT [FixedRows][FixedCols] = '{
    '{128'h79756e776569, "aaaa",           "bbbb",           128'h0},
    '{"yyw",             "abab",           "1234",           128'h0},
    '{"mnfe",            "notfound",       "fe",             128'h0},
    '{128'h6d696b756e6f74, "foundexception", "foundexception", 128'h0}
  };

  localparam int ENTRY_LEN [FixedRows][FixedCols] = '{
    '{6, 4, 4, 0},
    '{3, 4, 4, 0},
    '{4, 8, 2, 0},
    '{7, 14, 14, 0}
  };

  // Character k of an entry, zero past its end
  function automatic char_t entry_char(int r, int c, int k);
    char_t ch;
    ch = END_CHAR;
    if (k < ENTRY_LEN[r][c]) begin
      ch = ENTRY_TEXT[r][c][8*(ENTRY_LEN[r][c]-1-k) +: 8];
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

@@ design/url_path_allowlist_counter_unit.sv @@
// URL path allowlist counter.
// Input channel: one path byte per item (path_byte_i, in_valid_i / in_ready_o);
// a zero byte ends the path. Output channel: one result item per path
// (matched_o, reject_o, row_index_o, column_index_o, hit_count_o,
// out_valid_o / out_ready_i), produced only for the terminating byte.
// Each byte is matched on the fly against every allowlist entry by per-entry
// match flags, so no segment text is stored.
// Order: an accepted byte sits in the input register and is processed from there;
// a terminating byte is processed once the result register is free, and its
// result is then loaded into the result register, which drives the outputs.
// Throughput: one byte per cycle, sustained while no result waits on out_ready_i;
// the single pass from the input register to the result register sets this figure.
// Stall: a result waiting on out_ready_i holds back the next terminating byte,
// which then waits in the input register and blocks the bytes behind it; ordinary bytes ahead of it keep flowing.
// Reset: parse state returns to its start (match flags set), all hit counters clear to zero, both channels idle.
// Hit counters are 32 bits and saturate at all ones.
`default_nettype none

module url_path_allowlist_counter_unit #(
  parameter int SEGMENT_BYTES = upac_pkg::SegmentBytesDef,
  parameter int TABLE_ROWS    = upac_pkg::TableRowsDef,
  parameter int ROW_COLUMNS   = upac_pkg::RowColumnsDef
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  wire upac_pkg::char_t path_byte_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output logic                 matched_o,
  output logic                 reject_o,
  output logic [1:0]           row_index_o,
  output logic [1:0]           column_index_o,
  output upac_pkg::count_t     hit_count_o
);
  import upac_pkg::*;

  localparam int EffRows   = (TABLE_ROWS < FixedRows) ? TABLE_ROWS : FixedRows;
  localparam int EffCols   = (ROW_COLUMNS < FixedCols) ? ROW_COLUMNS : FixedCols;
  localparam int SecondCnt = EffCols - 1;
  localparam int SegLenW   = $clog2(SEGMENT_BYTES);
  localparam logic [SegLenW-1:0] SegLenCap = SegLenW'(SEGMENT_BYTES - 1);
  localparam logic [1:0] TakenNone  = 2'd0;
  localparam logic [1:0] TakenFirst = 2'd1;
  localparam logic [1:0] TakenBoth  = 2'd2;

  // Input register
  logic  in_valid_q;
  char_t byte_q;

  // Parse state
  logic                                slash_seen_q, slash_seen_d;
  logic [1:0]                          taken_q, taken_d;
  logic [SegLenW-1:0]                  seg_len_q, seg_len_d;
  logic                                too_long_q, too_long_d;
  logic [EffRows-1:0][EffCols-1:0]     cur_q, cur_d;
  logic [EffRows-1:0]                  first_ok_q, first_ok_d;
  logic [EffRows-1:0][EffCols-1:0]     second_ok_q, second_ok_d;
  logic [EffRows-1:0][SecondCnt-1:0][31:0] cnt_q, cnt_d;

  // Result register
  logic       out_valid_q;
  logic       matched_q, matched_d;
  logic [1:0] row_q, row_d;
  logic [1:0] col_q, col_d;
  count_t     count_q, count_d;

  // Combinational helpers
  logic                            is_end, is_delim, capturing, out_free, proc_fire;
  logic [EffRows-1:0][EffCols-1:0] char_ok, end_ok, second_fin;
  logic [EffRows-1:0]              first_fin;
  logic [1:0]                      taken_fin;
  logic                            found;
  count_t                          bumped;

  assign is_end    = (byte_q == END_CHAR);
  assign is_delim  = is_end || (byte_q == SLASH_CHAR);
  assign capturing = slash_seen_q && (taken_q != TakenBoth);
  assign out_free  = !out_valid_q || out_ready_i;
  assign proc_fire = in_valid_q && (!is_end || out_free);
  assign in_ready_o = !in_valid_q || proc_fire;

  // Per-entry byte compare and end-of-segment compare
  always_comb begin
    for (int r = 0; r < EffRows; r++) begin
      for (int c = 0; c < EffCols; c++) begin
        char_ok[r][c] = cur_q[r][c] && (byte_q == entry_char(r, c, int'(seg_len_q)));
        end_ok[r][c]  = cur_q[r][c] && !too_long_q && (int'(seg_len_q) == ENTRY_LEN[r][c]);
      end
    end
  end

  // Fold in the segment closed by this delimiter
  always_comb begin
    first_fin  = first_ok_q;
    second_fin = second_ok_q;
    taken_fin  = taken_q;
    if (capturing) begin
      taken_fin = taken_q + 2'd1;
      if (taken_q == TakenNone) begin
        for (int r = 0; r < EffRows; r++) first_fin[r] = end_ok[r][0];
      end else if (taken_q == TakenFirst) begin
        second_fin = end_ok;
      end
    end
  end

  // Lookup: first hit in row-major order wins, bump its counter
  always_comb begin
    found     = 1'b0;
    matched_d = 1'b0;
    row_d     = 2'd0;
    col_d     = 2'd0;
    count_d   = '0;
    cnt_d     = cnt_q;
    bumped    = '0;
    for (int r = 0; r < EffRows; r++) begin
      for (int c = 1; c < EffCols; c++) begin
        if (!found && taken_fin == TakenBoth && first_fin[r] && second_fin[r][c]) begin
          found     = 1'b1;
          bumped    = (cnt_q[r][c-1] == COUNT_MAX) ? COUNT_MAX : cnt_q[r][c-1] + 32'd1;
          cnt_d[r][c-1] = bumped;
          matched_d = 1'b1;
          row_d     = 2'(r);
          col_d     = 2'(c - 1);
          count_d   = bumped;
        end
      end
    end
  end

  // Parse state next values
  always_comb begin
    slash_seen_d = slash_seen_q;
    taken_d      = taken_q;
    seg_len_d    = seg_len_q;
    too_long_d   = too_long_q;
    cur_d        = cur_q;
    first_ok_d   = first_ok_q;
    second_ok_d  = second_ok_q;
    if (!is_delim) begin
      if (capturing) begin
        if (seg_len_q < SegLenCap) begin
          seg_len_d = seg_len_q + SegLenW'(1);
          cur_d     = char_ok;
        end else begin
          too_long_d = 1'b1;
        end
      end
    end else if (is_end) begin
      slash_seen_d = 1'b0;
      taken_d      = TakenNone;
      seg_len_d    = '0;
      too_long_d   = 1'b0;
      cur_d        = '1;
      first_ok_d   = '0;
      second_ok_d  = '0;
    end else begin
      taken_d      = taken_fin;
      first_ok_d   = first_fin;
      second_ok_d  = second_fin;
      slash_seen_d = 1'b1;
      seg_len_d    = '0;
      too_long_d   = 1'b0;
      cur_d        = '1;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= path_byte_i;
    end
  end

  // Advance parse state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slash_seen_q <= 1'b0;
      taken_q      <= TakenNone;
      seg_len_q    <= '0;
      too_long_q   <= 1'b0;
      cur_q        <= '1;
      first_ok_q   <= '0;
      second_ok_q  <= '0;
      cnt_q        <= '0;
    end else if (proc_fire) begin
      slash_seen_q <= slash_seen_d;
      taken_q      <= taken_d;
      seg_len_q    <= seg_len_d;
      too_long_q   <= too_long_d;
      cur_q        <= cur_d;
      first_ok_q   <= first_ok_d;
      second_ok_q  <= second_ok_d;
      if (is_end) begin
        cnt_q <= cnt_d;
      end
    end
  end

  // Result register: load on end of path, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc_fire && is_end) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire && is_end) begin
      matched_q <= matched_d;
      row_q     <= row_d;
      col_q     <= col_d;
      count_q   <= count_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign matched_o      = matched_q;
  assign reject_o       = !matched_q;
  assign row_index_o    = row_q;
  assign column_index_o = col_q;
  assign hit_count_o    = count_q;

endmodule

`default_nettype wire

@@ bench/path_result_checker.sv @@
`timescale 1ns / 100ps

module path_result_checker (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  input  wire                    in_ready_i,
  input  wire upac_pkg::char_t   path_byte_i,
  input  wire                    out_valid_i,
  input  wire                    out_ready_i,
  input  wire                    matched_i,
  input  wire                    reject_i,
  input  wire [1:0]              row_index_i,
  input  wire [1:0]              column_index_i,
  input  wire upac_pkg::count_t  hit_count_i,
  output int                     fail_count_o,
  output int                     pending_o,
  output int                     results_o,
  output int                     hits_o,
  output logic [11:0]            entries_hit_o
);

  localparam int KEEP_BYTES   = 31;
  localparam int ROWS         = 4;
  localparam int ALLOWED_COLS = 3;
  localparam int ENTRIES      = ROWS * ALLOWED_COLS;

  // Allowlist, right-justified text; column 0 is the first segment of a row
  localparam logic [127:0] ALLOWED [ROWS][4] = '{
    '{128'h79756e776569,   "aaaa",           "bbbb",           128'h0},
    '{"yyw",               "abab",           "1234",           128'h0},
    '{"mnfe",              "notfound",       "fe",             128'h0},
    '{128'h6d696b756e6f74, "foundexception", "foundexception", 128'h0}
  };

  localparam int ALLOWED_LEN [ROWS][4] = '{
    '{6, 4, 4, 0},
    '{3, 4, 4, 0},
    '{4, 8, 2, 0},
    '{7, 14, 14, 0}
  };

  typedef struct packed {
    logic             matched;
    logic             reject;
    logic [1:0]       row;
    logic [1:0]       col;
    upac_pkg::count_t count;
  } verdict_t;

  // Parse state of the path in flight
  logic             slash_seen;
  int               segs_taken;
  int               seg_len;
  logic             seg_long;
  upac_pkg::char_t  seg_buf [2][KEEP_BYTES];
  int               cap_len [2];
  logic             cap_long [2];

  upac_pkg::count_t hits_by_entry [ENTRIES];
  logic [11:0]      entries_hit;
  verdict_t         verdict_q [$];
  int               fails;
  int               results;
  int               hits;

  task automatic clear_parse();
    slash_seen  = 1'b0;
    segs_taken  = 0;
    seg_len     = 0;
    seg_long    = 1'b0;
    cap_len[0]  = 0;
    cap_len[1]  = 0;
    cap_long[0] = 1'b0;
    cap_long[1] = 1'b0;
  endtask

  // Pack a captured segment right-justified, like the table text
  function automatic logic [127:0] seg_text(input int s);
    logic [127:0] t;
    t = '0;
    for (int k = 0; k < cap_len[s]; k++) begin
      t = {t[119:0], seg_buf[s][k]};
    end
    return t;
  endfunction

  // Look the captured pair up and bump the saturating counter on a hit
  task automatic look_up_path(output verdict_t v);
    logic [127:0] t0;
    logic [127:0] t1;
    int           idx;
    v        = '0;
    v.reject = 1'b1;
    if (segs_taken >= 2 && !cap_long[0] && !cap_long[1]) begin
      t0 = seg_text(0);
      t1 = seg_text(1);
      for (int r = 0; r < ROWS; r++) begin
        if (!v.matched && cap_len[0] == ALLOWED_LEN[r][0] && t0 == ALLOWED[r][0]) begin
          for (int c = 1; c <= ALLOWED_COLS; c++) begin
            if (!v.matched && cap_len[1] == ALLOWED_LEN[r][c] && t1 == ALLOWED[r][c]) begin
              idx = r * ALLOWED_COLS + c - 1;
              if (hits_by_entry[idx] != upac_pkg::COUNT_MAX) begin
                hits_by_entry[idx] = hits_by_entry[idx] + 1;
              end
              entries_hit[idx] = 1'b1;
              v.matched = 1'b1;
              v.reject  = 1'b0;
              v.row     = 2'(r);
              v.col     = 2'(c - 1);
              v.count   = hits_by_entry[idx];
            end
          end
        end
      end
    end
  endtask

  // Advance the parse by one path byte; the end byte yields a verdict
  task automatic take_byte(input upac_pkg::char_t b);
    verdict_t v;
    if (b != upac_pkg::SLASH_CHAR && b != upac_pkg::END_CHAR) begin
      if (slash_seen && segs_taken < 2) begin
        if (seg_len < KEEP_BYTES) begin
          seg_buf[segs_taken][seg_len] = b;
          seg_len = seg_len + 1;
        end else begin
          seg_long = 1'b1;
        end
      end
    end else begin
      if (slash_seen && segs_taken < 2) begin
        cap_len[segs_taken]  = seg_len;
        cap_long[segs_taken] = seg_long;
        segs_taken = segs_taken + 1;
      end
      slash_seen = 1'b1;
      seg_len    = 0;
      seg_long   = 1'b0;
      if (b == upac_pkg::END_CHAR) begin
        look_up_path(v);
        verdict_q.push_back(v);
        clear_parse();
      end
    end
  endtask

  task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch on result %0d: %s got %0h, want %0h", results, field, got, want);
    fails = fails + 1;
  endtask

  // Compare one result item with the oldest verdict
  task automatic check_result();
    verdict_t want;
    if (verdict_q.size() == 0) begin
      report("result with nothing pending, hit_count", hit_count_i, 32'h0);
    end else begin
      want = verdict_q.pop_front();
      if (matched_i !== want.matched) begin
        report("matched", 32'(matched_i), 32'(want.matched));
      end
      if (reject_i !== want.reject) begin
        report("reject", 32'(reject_i), 32'(want.reject));
      end
      if (row_index_i !== want.row) begin
        report("row_index", 32'(row_index_i), 32'(want.row));
      end
      if (column_index_i !== want.col) begin
        report("column_index", 32'(column_index_i), 32'(want.col));
      end
      if (hit_count_i !== want.count) report("hit_count", hit_count_i, want.count);
      if (want.matched) hits = hits + 1;
    end
    results = results + 1;
  endtask

  // Watch both channels; publish counts for the top
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parse();
      for (int i = 0; i < ENTRIES; i++) hits_by_entry[i] = '0;
      verdict_q.delete();
      entries_hit = '0;
      fails       = 0;
      results     = 0;
      hits        = 0;
    end else begin
      if (in_valid_i && in_ready_i) take_byte(path_byte_i);
      if (out_valid_i && out_ready_i) check_result();
    end
    fail_count_o  <= fails;
    pending_o     <= verdict_q.size();
    results_o     <= results;
    hits_o        <= hits;
    entries_hit_o <= entries_hit;
  end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps

module tb;

  localparam int TARGET_BYTES = 1950;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 8;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid;
  logic             in_ready;
  upac_pkg::char_t  path_byte;
  logic             out_valid;
  logic             out_ready;
  logic             matched;
  logic             reject;
  logic [1:0]       row_index;
  logic [1:0]       column_index;
  upac_pkg::count_t hit_count;

  int               fail_count;
  int               pending;
  int               results;
  int               hits;
  logic [11:0]      entries_hit;
  int               idle_cycles;
  int               bytes_sent;
  upac_pkg::char_t  path_q [$];

  url_path_allowlist_counter_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .path_byte_i    (path_byte),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .matched_o      (matched),
    .reject_o       (reject),
    .row_index_o    (row_index),
    .column_index_o (column_index),
    .hit_count_o    (hit_count)
  );

  path_result_checker path_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .path_byte_i    (path_byte),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .matched_i      (matched),
    .reject_i       (reject),
    .row_index_i    (row_index),
    .column_index_i (column_index),
    .hit_count_i    (hit_count),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .results_o      (results),
    .hits_o         (hits),
    .entries_hit_o  (entries_hit)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Mostly short pauses, now and then a long one
  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic upac_pkg::char_t letter();
    if ($urandom_range(0, 4) == 0) return 8'h30 + 8'($urandom_range(0, 9));
    return 8'h61 + 8'($urandom_range(0, 25));
  endfunction

  // Any byte that neither ends the path nor splits a segment
  function automatic upac_pkg::char_t text_byte();
    upac_pkg::char_t b;
    b = 8'($urandom_range(1, 255));
    if (b == upac_pkg::SLASH_CHAR) b = 8'h5C;
    return b;
  endfunction

  task automatic add_entry(input int r, input int c);
    int n;
    n = upac_pkg::ENTRY_LEN[r][c];
    for (int k = 0; k < n; k++) begin
      path_q.push_back(upac_pkg::ENTRY_TEXT[r][c][8*(n-1-k) +: 8]);
    end
  endtask

  task automatic add_text(input int n, input bit any_byte);
    for (int k = 0; k < n; k++) path_q.push_back(any_byte ? text_byte() : letter());
  endtask

  task automatic add_str(input string s);
    for (int k = 0; k < s.len(); k++) path_q.push_back(s[k]);
  endtask

  // One segment: mostly table text, else near misses, junk or overlong text
  task automatic add_segment(input int r, input int c);
    int pick;
    int n;
    int ofs;
    pick = $urandom_range(0, 99);
    n    = upac_pkg::ENTRY_LEN[r][c];
    if (pick < 65) begin
      add_entry(r, c);
    end else if (pick < 73) begin
      add_entry($urandom_range(0, 3), $urandom_range(0, 3));
    end else if (pick < 83) begin
      add_entry(r, c);
      if (n > 0 && $urandom_range(0, 1) == 0) begin
        ofs = $urandom_range(1, n);
        path_q[path_q.size() - ofs] = letter();
      end else begin
        path_q.push_back(letter());
      end
    end else if (pick < 93) begin
      add_text($urandom_range(0, 8), 1'b0);
    end else if (pick < 96) begin
      add_text($urandom_range(1, 12), 1'b1);
    end else begin
      add_text($urandom_range(29, 40), 1'b0);
    end
  endtask

  // Build one random path ending in the end byte
  task automatic gen_path();
    int pick;
    int r;
    pick = $urandom_range(0, 99);
    r    = $urandom_range(0, 3);
    if (pick < 72) begin
      // well-formed: optional text before the first slash, extra segments
      if ($urandom_range(0, 9) == 0) add_text($urandom_range(1, 3), 1'b1);
      path_q.push_back(upac_pkg::SLASH_CHAR);
      add_segment(r, 0);
      path_q.push_back(upac_pkg::SLASH_CHAR);
      add_segment(r, $urandom_range(1, 3));
      if ($urandom_range(0, 6) == 0) begin
        path_q.push_back(upac_pkg::SLASH_CHAR);
        add_text($urandom_range(0, 6), 1'b0);
      end
      if ($urandom_range(0, 9) == 0) path_q.push_back(upac_pkg::SLASH_CHAR);
    end else if (pick < 90) begin
      // fewer than two segments
      case ($urandom_range(0, 3))
        0: ;
        1: add_text($urandom_range(1, 6), 1'b1);
        2: begin
          path_q.push_back(upac_pkg::SLASH_CHAR);
          add_segment(r, 0);
        end
        default: begin
          add_text($urandom_range(1, 3), 1'b0);
          path_q.push_back(upac_pkg::SLASH_CHAR);
          add_segment(r, 0);
        end
      endcase
    end else begin
      // raw noise of any byte value
      repeat ($urandom_range(1, 10)) path_q.push_back(8'($urandom_range(0, 255)));
    end
    path_q.push_back(upac_pkg::END_CHAR);
  endtask

  // Offer one item after an optional pause; hold it until accepted
  task automatic send_byte(input upac_pkg::char_t b, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    path_byte <= b;
    in_valid  <= 1'b1;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    bytes_sent = bytes_sent + 1;
    @(negedge clk_i);
  endtask

  task automatic send_path();
    bit burst;
    burst = ($urandom_range(0, 3) == 0);
    foreach (path_q[i]) send_byte(path_q[i], burst ? 0 : pause_len());
    path_q.delete();
  endtask

  // Result side: runs of ready, short stalls, a few long ones
  initial begin
    int hold;
    int r;
    out_ready = 1'b0;
    hold      = 0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        hold = hold - 1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          out_ready <= 1'b1;
          hold = $urandom_range(0, 29);
        end else if (r < 65) begin
          out_ready <= 1'b1;
          hold = $urandom_range(100, 300);
        end else begin
          out_ready <= 1'b0;
          hold = pause_len();
        end
      end
    end
  end

  // Stop the run when no item moves on either channel for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("no item moved for %0d cycles", IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni     = 1'b0;
    in_valid   = 1'b0;
    path_byte  = '0;
    bytes_sent = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extreme bytes, no slash, one segment, a hit, empty second
    // segment followed by a third one
    path_q.push_back(8'hFF);
    path_q.push_back(upac_pkg::END_CHAR);
    add_str("ab/");
    path_q.push_back(upac_pkg::END_CHAR);
    add_str("/yyw/1234");
    path_q.push_back(upac_pkg::END_CHAR);
    add_str("/mnfe//x");
    path_q.push_back(upac_pkg::END_CHAR);
    send_path();

    // random paths
    while (bytes_sent < TARGET_BYTES) begin
      gen_path();
      send_path();
    end
    in_valid <= 1'b0;

    // drain
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d path bytes; checked %0d verdicts, %0d of them allowlist hits",
             bytes_sent, results, hits);
    $display("Allowlist entries hit at least once: %0d of 12", $countones(entries_hit));
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/upac_pkg.sv
design/url_path_allowlist_counter_unit.sv
bench/path_result_checker.sv
bench/tb.sv
